FILE: rtl/wfs_pkg.sv
// Package for the winnowing fingerprint selector: field widths, defaults,
// register map. No dependencies.
package wfs_pkg;

  localparam int HASH_W    = 64;  // k-gram hash width
  localparam int POS_OUT_W = 20;  // fingerprint position width on the port
  localparam int WIN_CFG_W = 5;   // window_size register width

  localparam int     DEF_MAX_WINDOW   = 16;
  localparam longint DEF_MAX_SEQUENCE = 64'd1048576;

  localparam logic [WIN_CFG_W-1:0] WIN_RESET = 5'd4;

  // APB register map: byte address 4*index, index taken from paddr[2]
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

endpackage

FILE: rtl/wfs_intf.sv
// Valid/ready channel interfaces for hash words in and fingerprint words out.
// Depends on wfs_pkg.
interface wfs_in_if;
  import wfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;
  logic              seq_last;
  modport source (output valid, output hash_value, output seq_last, input ready);
  modport sink   (input valid, input hash_value, input seq_last, output ready);
endinterface

interface wfs_out_if;
  import wfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [HASH_W-1:0]    fingerprint_hash;
  logic [POS_OUT_W-1:0] fingerprint_position;
  modport source (output valid, output fingerprint_hash, output fingerprint_position,
                  input ready);
  modport sink   (input valid, input fingerprint_hash, input fingerprint_position,
                  output ready);
endinterface

FILE: rtl/wfs_win_ram.sv
// Window store: simple dual-port synchronous RAM, one write and one read
// port, registered read data. No dependencies.
module wfs_win_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 84
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/winnowing_fingerprint_select_core.sv
// Winnowing fingerprint selector top level: circular window RAM, scan
// sequencer, output register, APB register file.
// Depends on wfs_pkg, wfs_intf (wfs_in_if, wfs_out_if), wfs_win_ram.
//
//  channel   dir  word                                   handshake
//  in_ch     in   hash_value[63:0], seq_last             valid/ready
//  out_ch    out  fingerprint_hash[63:0],                 valid/ready
//                 fingerprint_position[19:0]
//  apb       in   window_size at byte address 0          psel/penable, pready=1
//
// Flow: an item that selects nothing goes straight back to idle; otherwise
//   the scan reads span - 1 older entries, span = min(window_size, MAX_WINDOW)
//   (or the hashes seen, for a short sequence), one window RAM read per older entry on one read port.
// Reset: rst (synchronous, active high) clears sequence state and sets
//   window_size to 4; the window RAM holds no reset and needs no clear pass.
// Stalls: the input is taken in the idle state even while a fingerprint waits
//   in the output register; a finished item waits in its final state only
//   when the output register is still full.
module winnowing_fingerprint_select_core #(
  parameter int     MAX_WINDOW   = wfs_pkg::DEF_MAX_WINDOW,
  parameter longint MAX_SEQUENCE = wfs_pkg::DEF_MAX_SEQUENCE
) (
  input  logic                       clk,
  input  logic                       rst,
  wfs_in_if.sink                     in_ch,
  wfs_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wfs_pkg::APB_AW-1:0] paddr,
  input  logic [wfs_pkg::APB_DW-1:0] pwdata,
  output logic [wfs_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import wfs_pkg::*;

  localparam int POS_W = $clog2(MAX_SEQUENCE);      // holds MAX_SEQUENCE - 1
  localparam int CNT_W = $clog2(MAX_SEQUENCE + 1);  // holds MAX_SEQUENCE
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);    // holds MAX_WINDOW
  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int DW    = POS_W + HASH_W;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEQUENCE);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SEQUENCE - 1);
  localparam logic [WIN_W-1:0] W_MAX   = WIN_W'(MAX_WINDOW);
  localparam logic [AW-1:0]    PTR_TOP = AW'(MAX_WINDOW - 1);
  localparam logic [AW:0]      DEPTH_X = (AW + 1)'(MAX_WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FINAL = 3'b100
  } state_t;

  // ---------------- configuration ----------------
  logic [WIN_CFG_W-1:0] window_size;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_RESET;
    end else if (cfg_wr) begin
      window_size <= pwdata[WIN_CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW_SIZE) begin
      prdata = APB_DW'(window_size);
    end
  end

  // ---------------- sequence state ----------------
  state_t            state, state_next;
  logic [CNT_W-1:0]  item_count;
  logic [AW-1:0]     wr_ptr;
  logic [POS_W-1:0]  prev_pos;
  logic              prev_valid;

  // latched item
  logic [HASH_W-1:0] cur_hash;
  logic [POS_W-1:0]  cur_pos;
  logic              cur_last;
  logic              cur_full;
  logic [AW-1:0]     base;      // RAM address of the newest entry

  // scan
  logic [WIN_W-1:0]  rd_age;
  logic              rd_pend;
  logic [HASH_W-1:0] best_hash;
  logic [POS_W-1:0]  best_pos;

  // output register
  logic              out_valid;
  logic [HASH_W-1:0]    out_hash;
  logic [POS_OUT_W-1:0] out_pos;

  logic in_acc;
  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Effective window, position and count for the incoming hash
  logic [WIN_W-1:0] w_eff;
  logic [POS_W-1:0] pos_now;
  logic [CNT_W-1:0] cnt_inc;
  logic             full_in;
  logic [WIN_W-1:0] span_in;

  always_comb begin
    if (int'(window_size) > MAX_WINDOW) begin
      w_eff = W_MAX;
    end else begin
      w_eff = WIN_W'(window_size);
    end
    pos_now = (item_count < CNT_MAX) ? POS_W'(item_count) : POS_MAX;
    cnt_inc = (item_count < CNT_MAX) ? item_count + 1'b1 : item_count;
    full_in = (w_eff != '0) && (CMP_W'(cnt_inc) >= CMP_W'(w_eff));
    if (full_in) begin
      span_in = w_eff;
    end else if (in_ch.seq_last && (w_eff != '0)) begin
      span_in = WIN_W'(cnt_inc);  // short sequence: all hashes seen
    end else begin
      span_in = '0;
    end
  end

  // RAM read address: newest minus age, wrapped around the ring
  logic [AW:0]   addr_sum;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  always_comb begin
    addr_sum = {1'b0, base} + DEPTH_X - (AW + 1)'(rd_age);
    if (addr_sum >= DEPTH_X) begin
      addr_sum = addr_sum - DEPTH_X;
    end
    rd_addr = addr_sum[AW-1:0];
  end

  assign rd_en = (state == ST_SCAN) && (rd_age != '0);

  logic [DW-1:0]     rd_data;
  logic [HASH_W-1:0] rd_hash;
  logic [POS_W-1:0]  rd_pos;
  assign rd_hash = rd_data[HASH_W-1:0];
  assign rd_pos  = rd_data[DW-1:HASH_W];

  wfs_win_ram #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW),
    .DW    (DW)
  ) u_win_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wr_ptr),
    .wdata ({pos_now, in_ch.hash_value}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Final pick: the current hash is the newest, so it wins ties
  logic [HASH_W-1:0] sel_hash;
  logic [POS_W-1:0]  sel_pos;
  logic              emit;
  logic              out_free;

  always_comb begin
    if (cur_hash <= best_hash) begin
      sel_hash = cur_hash;
      sel_pos  = cur_pos;
    end else begin
      sel_hash = best_hash;
      sel_pos  = best_pos;
    end
    // short sequences are never suppressed
    emit     = !cur_full || !prev_valid || (prev_pos != sel_pos);
    out_free = !out_valid || out_ch.ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (span_in != '0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_age == '0) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!emit || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      item_count <= '0;
      wr_ptr     <= '0;
      prev_pos   <= '0;
      prev_valid <= 1'b0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      // a new fingerprint may load in the same cycle the old one leaves
      if ((state == ST_FINAL) && emit && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        item_count <= in_ch.seq_last ? '0 : cnt_inc;
        wr_ptr     <= (wr_ptr == PTR_TOP) ? '0 : wr_ptr + 1'b1;
        if (in_ch.seq_last && (span_in == '0)) begin
          prev_pos   <= '0;
          prev_valid <= 1'b0;
        end
      end
      if ((state == ST_FINAL) && (!emit || out_free)) begin
        // end of sequence wipes the last fingerprint
        if (cur_last) begin
          prev_pos   <= '0;
          prev_valid <= 1'b0;
        end else if (emit) begin
          prev_pos   <= sel_pos;
          prev_valid <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_hash  <= in_ch.hash_value;
      cur_pos   <= pos_now;
      cur_last  <= in_ch.seq_last;
      cur_full  <= full_in;
      base      <= wr_ptr;
      rd_age    <= (span_in != '0) ? span_in - 1'b1 : '0;
      best_hash <= '1;  // any stored hash is <= all ones
      best_pos  <= '0;
    end else if (state == ST_SCAN) begin
      if (rd_en) begin
        rd_age <= rd_age - 1'b1;
      end
      // oldest first, <= lets newer equal hashes take over
      if (rd_pend && (rd_hash <= best_hash)) begin
        best_hash <= rd_hash;
        best_pos  <= rd_pos;
      end
    end
    if ((state == ST_FINAL) && emit && out_free) begin
      out_hash <= sel_hash;
      out_pos  <= POS_OUT_W'(sel_pos);
    end
  end

  assign out_ch.valid                = out_valid;
  assign out_ch.fingerprint_hash     = out_hash;
  assign out_ch.fingerprint_position = out_pos;

endmodule
